/* rtl/brsp_pkg.sv */
// ----------------------------------------------------------------------------
// brsp_pkg
// Types and codes shared by the backup request stream parser files.
// ----------------------------------------------------------------------------
package brsp_pkg;

    // parser phase
    typedef enum logic [3:0] {
        PH_VER    = 4'd0,
        PH_CMD    = 4'd1,
        PH_ECHO   = 4'd2,
        PH_NAME   = 4'd3,
        PH_COUNT  = 4'd4,
        PH_PATH   = 4'd5,
        PH_TYPE   = 4'd6,
        PH_HASH   = 4'd7,
        PH_CLOSED = 4'd8
    } t_phase;

    // tag carried by every result item
    typedef enum logic [3:0] {
        K_VERSION  = 4'd0,
        K_COMMAND  = 4'd1,
        K_ECHO     = 4'd2,
        K_NAME     = 4'd3,
        K_NAME_END = 4'd4,
        K_COUNT    = 4'd5,
        K_PATH     = 4'd6,
        K_PATH_END = 4'd7,
        K_TYPE     = 4'd8,
        K_HASH     = 4'd9,
        K_REPLY    = 4'd10,
        K_DISCARD  = 4'd11
    } t_kind;

    // closing error codes
    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_CMD  = 2'd1,
        ERR_TYPE = 2'd2
    } t_err;

    // byte values of the protocol
    localparam logic [7:0] CMD_ECHO     = 8'h00;
    localparam logic [7:0] CMD_BACKUP   = 8'h01;
    localparam logic [7:0] STR_TERM     = 8'h00;
    localparam logic [7:0] TYPE_FILE    = 8'h66;
    localparam logic [7:0] TYPE_DIR     = 8'h64;
    localparam logic [7:0] REPLY_FIRST  = 8'h01;
    localparam logic [7:0] REPLY_SECOND = 8'h00;
    localparam logic [1:0] COUNT_LAST   = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
    } t_in_item;

    typedef struct packed {
        t_kind       event_kind;
        logic [7:0]  out_byte;
        logic [4:0]  field_pos;
        logic [31:0] files_left;
        logic [7:0]  proto_version;
        t_err        error_code;
        logic        closed;
        logic        last;
    } t_out_item;

    // parser state carried between items
    typedef struct packed {
        t_phase      phase;
        logic [7:0]  version;
        logic [31:0] file_counter;
        logic [4:0]  byte_index;
        t_err        err;
    } t_state;

endpackage

/* rtl/brsp_stream_if.sv */
// ----------------------------------------------------------------------------
// brsp_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface brsp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/brsp_step.sv */
// ----------------------------------------------------------------------------
// brsp_step
// Next parser state and first result item for one received byte.
// ----------------------------------------------------------------------------
module brsp_step import brsp_pkg::*; #(
    parameter int HASH_BYTES = 20
) (
    input  t_state     i_state,
    input  logic [7:0] i_byte,
    output t_state     o_state,
    output t_out_item  o_item,
    output logic       o_reply
);

    localparam logic [4:0] HASH_LAST = 5'(HASH_BYTES - 1);

    t_state     n_state;
    t_kind      w_kind;
    logic [4:0] w_pos;
    logic       w_reply;

    // one phase step per byte
    always_comb begin
        n_state = i_state;
        w_kind  = K_VERSION;
        w_pos   = 5'd0;
        w_reply = 1'b0;
        case (i_state.phase)
            PH_CMD: begin
                w_kind = K_COMMAND;
                if (i_byte == CMD_ECHO) begin
                    n_state.phase = PH_ECHO;
                end else if (i_byte == CMD_BACKUP) begin
                    n_state.phase        = PH_NAME;
                    n_state.file_counter = 32'd0;
                end else begin
                    n_state.phase = PH_CLOSED;
                    n_state.err   = ERR_CMD;
                end
            end
            PH_ECHO: begin
                w_kind = K_ECHO;
            end
            PH_NAME: begin
                if (i_byte == STR_TERM) begin
                    w_kind               = K_NAME_END;
                    n_state.phase        = PH_COUNT;
                    n_state.byte_index   = 5'd0;
                    n_state.file_counter = 32'd0;
                end else begin
                    w_kind = K_NAME;
                end
            end
            PH_COUNT: begin
                w_kind               = K_COUNT;
                w_pos                = {3'd0, i_state.byte_index[1:0]};
                n_state.file_counter = {i_state.file_counter[23:0], i_byte};
                if (i_state.byte_index[1:0] == COUNT_LAST) begin
                    n_state.byte_index = 5'd0;
                    if (n_state.file_counter == 32'd0) begin
                        w_reply       = 1'b1;
                        n_state.phase = PH_VER;
                    end else begin
                        n_state.phase = PH_PATH;
                    end
                end else begin
                    n_state.byte_index = w_pos + 5'd1;
                end
            end
            PH_PATH: begin
                if (i_byte == STR_TERM) begin
                    w_kind        = K_PATH_END;
                    n_state.phase = PH_TYPE;
                end else begin
                    w_kind = K_PATH;
                end
            end
            PH_TYPE: begin
                w_kind = K_TYPE;
                if (i_byte == TYPE_FILE) begin
                    n_state.phase      = PH_HASH;
                    n_state.byte_index = 5'd0;
                end else if (i_byte == TYPE_DIR) begin
                    // directory entry has no hash, count it down now
                    n_state.file_counter = i_state.file_counter - 32'd1;
                    if (n_state.file_counter == 32'd0) begin
                        w_reply       = 1'b1;
                        n_state.phase = PH_VER;
                    end else begin
                        n_state.phase = PH_PATH;
                    end
                end else begin
                    n_state.phase = PH_CLOSED;
                    n_state.err   = ERR_TYPE;
                end
            end
            PH_HASH: begin
                w_kind = K_HASH;
                w_pos  = i_state.byte_index;
                if (i_state.byte_index >= HASH_LAST) begin
                    n_state.byte_index   = 5'd0;
                    n_state.file_counter = i_state.file_counter - 32'd1;
                    if (n_state.file_counter == 32'd0) begin
                        w_reply       = 1'b1;
                        n_state.phase = PH_VER;
                    end else begin
                        n_state.phase = PH_PATH;
                    end
                end else begin
                    n_state.byte_index = i_state.byte_index + 5'd1;
                end
            end
            PH_CLOSED: begin
                w_kind = K_DISCARD;
            end
            default: begin
                // header version byte, also for unused phase codes
                w_kind          = K_VERSION;
                n_state.version = i_byte;
                n_state.phase   = PH_CMD;
            end
        endcase
    end

    // result fields show the state after this byte
    always_comb begin
        o_item.event_kind    = w_kind;
        o_item.out_byte      = i_byte;
        o_item.field_pos     = w_pos;
        o_item.files_left    = n_state.file_counter;
        o_item.proto_version = n_state.version;
        o_item.error_code    = n_state.err;
        o_item.closed        = (n_state.phase == PH_CLOSED);
        o_item.last          = !w_reply;
    end

    assign o_state = n_state;
    assign o_reply = w_reply;

endmodule

/* rtl/backup_request_stream_parser.sv */
// ----------------------------------------------------------------------------
// backup_request_stream_parser
// Tags each received byte of a backup connection and emits request replies.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                   handshake
//  i_in     in   in_byte                                   valid/ready
//  o_out    out  event_kind, out_byte, field_pos,          valid/ready
//                files_left, proto_version, error_code,
//                closed, last
//
//  one byte per cycle while the output takes items and no reply is owed:
//  input register, one step of parse logic, result register
//  a byte that ends a request yields three items and holds the parser while
//  the reply bytes 01 00 leave the result register
//  reset puts the parser in the header phase with all counters cleared
//  a stalled output holds the result register; the input register still
//  takes one byte while it waits
//
module backup_request_stream_parser import brsp_pkg::*; #(
    parameter int HASH_BYTES = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    brsp_stream_if.sink   i_in,
    brsp_stream_if.source o_out
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_state     r_state;
    t_out_item  r_out;
    logic       r_out_valid;
    logic [1:0] r_reply_left;

    t_state     w_next;
    t_out_item  w_first;
    logic       w_reply;
    logic       w_out_free;
    logic       w_advance;
    logic       w_pop;

    // parse step
    brsp_step #(
        .HASH_BYTES (HASH_BYTES)
    ) u_step (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .o_state (w_next),
        .o_item  (w_first),
        .o_reply (w_reply)
    );

    // flow control
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_advance   = r_in_valid && w_out_free && (r_reply_left == 2'd0);
    assign w_pop       = r_out_valid && o_out.ready;
    assign i_in.ready  = !r_in_valid || w_advance;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data.in_byte;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase        <= PH_VER;
            r_state.version      <= 8'd0;
            r_state.file_counter <= 32'd0;
            r_state.byte_index   <= 5'd0;
            r_state.err          <= ERR_NONE;
        end else if (w_advance) begin
            r_state <= w_next;
        end
    end

    // result register control, reply bytes follow the item that ends a request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_reply_left <= 2'd0;
        end else if (w_advance) begin
            r_out_valid  <= 1'b1;
            r_reply_left <= w_reply ? 2'd2 : 2'd0;
        end else if (w_pop) begin
            if (r_reply_left != 2'd0) begin
                r_reply_left <= r_reply_left - 2'd1;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_first;
        end else if (w_pop && (r_reply_left != 2'd0)) begin
            r_out.event_kind <= K_REPLY;
            r_out.out_byte   <= (r_reply_left == 2'd2) ? REPLY_FIRST : REPLY_SECOND;
            r_out.field_pos  <= 5'd0;
            r_out.files_left <= 32'd0;
            r_out.last       <= (r_reply_left == 2'd1);
        end
    end

`ifndef ASSERT_OFF
    // pending reply bytes always sit behind a valid result
    a_reply_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_reply_left != 2'd0) |-> r_out_valid)
        else $error("reply pending without a valid result");

    // no new byte is parsed while reply bytes are still owed
    a_no_parse_in_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |-> (r_reply_left == 2'd0))
        else $error("byte parsed during reply");

    // the first reply byte is followed by exactly one more
    a_reply_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.event_kind == K_REPLY) && !r_out.last)
        |-> (r_reply_left == 2'd1))
        else $error("reply byte count out of step");

    // a closed stream stays closed
    a_closed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_CLOSED) |=> (r_state.phase == PH_CLOSED))
        else $error("closed stream reopened");
`endif

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Byte stream test of the backup request stream parser. A directed table
// walks the header, name, count, path and type fields, the zero count and the
// directory entries. Random backup requests with random names, paths and
// hashes follow. One closing sequence per run (echo, unknown command or bad
// type byte) ends the stream. Every result item is checked field by field
// against the bench's byte-level parser model or a typed directed row.
// ----------------------------------------------------------------------------
module tb_top import brsp_pkg::*;;

    localparam int HASH_LEN     = 20;
    localparam int RANDOM_BYTES = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int EXP_DEPTH    = 1024;
    localparam int DIR_MAX      = 32;

    // directed stimulus row, with an optional typed first result
    typedef struct packed {
        logic [7:0] b;
        logic       typed;
        t_out_item  ev;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    brsp_stream_if #(.T(t_in_item))  in_if ();
    brsp_stream_if #(.T(t_out_item)) out_if ();

    backup_request_stream_parser #(
        .HASH_BYTES(HASH_LEN)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // parser model state
    t_phase      mdl_phase;
    logic [7:0]  mdl_version;
    logic [31:0] mdl_files;
    logic [4:0]  mdl_index;
    t_err        mdl_err;

    // expected result items, written on input acceptance, read on output
    t_out_item   exp_fifo[EXP_DEPTH];
    int          exp_wr     = 0;
    int          exp_rd     = 0;
    t_dir_row    dir_rows[DIR_MAX];
    int          dir_count  = 0;
    int          mismatches = 0;
    int          bytes_sent = 0;
    bit          in_calm    = 1'b0;
    bit          out_calm   = 1'b0;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // overall time limit
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic t_out_item make_event(t_kind kind, logic [7:0] b, logic [4:0] pos,
                                             logic [31:0] left, logic [7:0] ver, t_err err,
                                             logic closed, logic last);
        t_out_item e;
        e.event_kind    = kind;
        e.out_byte      = b;
        e.field_pos     = pos;
        e.files_left    = left;
        e.proto_version = ver;
        e.error_code    = err;
        e.closed        = closed;
        e.last          = last;
        return e;
    endfunction

    // queue one event tagged with the current model state
    function automatic void note_event(t_kind kind, logic [7:0] b, logic [4:0] pos,
                                       logic [31:0] left, logic last);
        exp_fifo[exp_wr % EXP_DEPTH] = make_event(kind, b, pos, left, mdl_version, mdl_err,
                                                  mdl_phase == PH_CLOSED, last);
        exp_wr++;
    endfunction

    // request complete: reply bytes 01 00, back to the header
    function automatic void note_reply();
        mdl_phase = PH_VER;
        note_event(K_REPLY, REPLY_FIRST, 5'd0, 32'd0, 1'b0);
        note_event(K_REPLY, REPLY_SECOND, 5'd0, 32'd0, 1'b1);
    endfunction

    // one file entry done; returns 1 when it was the last of the request
    function automatic bit finish_file();
        mdl_files = mdl_files - 32'd1;
        if (mdl_files == 32'd0) begin
            mdl_phase = PH_VER;
            return 1'b1;
        end
        mdl_phase = PH_PATH;
        return 1'b0;
    endfunction

    // advance the parser model by one accepted byte
    function automatic void parse_byte(logic [7:0] b);
        logic [4:0] pos;
        bit         done;
        case (mdl_phase)
            PH_CMD: begin
                if (b == CMD_ECHO) begin
                    mdl_phase = PH_ECHO;
                end else if (b == CMD_BACKUP) begin
                    mdl_phase = PH_NAME;
                    mdl_files = 32'd0;
                end else begin
                    mdl_phase = PH_CLOSED;
                    mdl_err   = ERR_CMD;
                end
                note_event(K_COMMAND, b, 5'd0, mdl_files, 1'b1);
            end
            PH_ECHO: note_event(K_ECHO, b, 5'd0, mdl_files, 1'b1);
            PH_NAME: begin
                if (b == STR_TERM) begin
                    mdl_phase = PH_COUNT;
                    mdl_index = 5'd0;
                    mdl_files = 32'd0;
                    note_event(K_NAME_END, b, 5'd0, mdl_files, 1'b1);
                end else begin
                    note_event(K_NAME, b, 5'd0, mdl_files, 1'b1);
                end
            end
            PH_COUNT: begin
                pos       = {3'd0, mdl_index[1:0]};
                mdl_files = {mdl_files[23:0], b};
                if (pos[1:0] == COUNT_LAST) begin
                    mdl_index = 5'd0;
                    if (mdl_files == 32'd0) begin
                        // zero count: reply right after the last count byte
                        note_event(K_COUNT, b, pos, mdl_files, 1'b0);
                        note_reply();
                    end else begin
                        mdl_phase = PH_PATH;
                        note_event(K_COUNT, b, pos, mdl_files, 1'b1);
                    end
                end else begin
                    mdl_index = pos + 5'd1;
                    note_event(K_COUNT, b, pos, mdl_files, 1'b1);
                end
            end
            PH_PATH: begin
                if (b == STR_TERM) begin
                    mdl_phase = PH_TYPE;
                    note_event(K_PATH_END, b, 5'd0, mdl_files, 1'b1);
                end else begin
                    note_event(K_PATH, b, 5'd0, mdl_files, 1'b1);
                end
            end
            PH_TYPE: begin
                if (b == TYPE_FILE) begin
                    mdl_phase = PH_HASH;
                    mdl_index = 5'd0;
                    note_event(K_TYPE, b, 5'd0, mdl_files, 1'b1);
                end else if (b == TYPE_DIR) begin
                    done = finish_file();
                    note_event(K_TYPE, b, 5'd0, mdl_files, !done);
                    if (done) note_reply();
                end else begin
                    mdl_phase = PH_CLOSED;
                    mdl_err   = ERR_TYPE;
                    note_event(K_TYPE, b, 5'd0, mdl_files, 1'b1);
                end
            end
            PH_HASH: begin
                pos = mdl_index;
                if (pos >= HASH_LEN - 1) begin
                    mdl_index = 5'd0;
                    done = finish_file();
                    note_event(K_HASH, b, pos, mdl_files, !done);
                    if (done) note_reply();
                end else begin
                    mdl_index = pos + 5'd1;
                    note_event(K_HASH, b, pos, mdl_files, 1'b1);
                end
            end
            PH_CLOSED: note_event(K_DISCARD, b, 5'd0, mdl_files, 1'b1);
            default: begin
                mdl_version = b;
                mdl_phase   = PH_CMD;
                note_event(K_VERSION, b, 5'd0, mdl_files, 1'b1);
            end
        endcase
    endfunction

    function automatic t_dir_row row(logic [7:0] b);
        return '{b: b, typed: 1'b0, ev: '0};
    endfunction

    function automatic t_dir_row typed_row(logic [7:0] b, t_out_item ev);
        return '{b: b, typed: 1'b1, ev: ev};
    endfunction

    // append one row to the directed table
    function automatic void add_row(t_dir_row r);
        dir_rows[dir_count] = r;
        dir_count++;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_val,
                                        logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    // send one byte after a random gap; the model takes it on acceptance
    task automatic send_byte(logic [7:0] b, bit typed = 1'b0, t_out_item typed_ev = '0);
        int gap;
        int slot;
        gap = in_calm ? 0 : int'($urandom_range(0, 5));
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= t_in_item'(b);
        do @(posedge i_clk); while (!in_if.ready);
        slot = exp_wr;
        parse_byte(b);
        if (typed) exp_fifo[slot % EXP_DEPTH] = typed_ev;
        bytes_sent++;
        if ($urandom_range(0, 19) == 0) in_calm = !in_calm;
    endtask

    // zero-terminated string of nonzero random bytes
    task automatic send_string(int len);
        repeat (len) send_byte(8'($urandom_range(1, 255)));
        send_byte(STR_TERM);
    endtask

    task automatic send_count(logic [31:0] cnt);
        send_byte(cnt[31:24]);
        send_byte(cnt[23:16]);
        send_byte(cnt[15:8]);
        send_byte(cnt[7:0]);
    endtask

    task automatic send_file_entry();
        send_string($urandom_range(0, 4));
        if ($urandom_range(0, 1)) begin
            send_byte(TYPE_FILE);
            repeat (HASH_LEN) send_byte(8'($urandom_range(0, 255)));
        end else begin
            send_byte(TYPE_DIR);
        end
    endtask

    task automatic send_backup_request();
        int files;
        files = ($urandom_range(0, 5) == 0) ? 0 : int'($urandom_range(1, 3));
        send_byte(8'($urandom_range(0, 255)));
        send_byte(CMD_BACKUP);
        send_string($urandom_range(0, 6));
        send_count(32'(files));
        repeat (files) send_file_entry();
    endtask

    // the stream ends in echo mode, an unknown command or a bad type byte
    task automatic send_closing_tail();
        int          mode;
        logic [7:0]  bad;
        logic [31:0] cnt;
        mode = $urandom_range(0, 2);
        send_byte(8'($urandom_range(0, 255)));
        case (mode)
            0: send_byte(CMD_ECHO);
            1: send_byte(8'($urandom_range(2, 255)));
            default: begin
                send_byte(CMD_BACKUP);
                send_string($urandom_range(0, 3));
                cnt = $urandom();
                if (cnt == 32'd0) cnt = 32'd1;
                send_count(cnt);
                send_string($urandom_range(0, 3));
                do bad = 8'($urandom_range(0, 255)); while (bad == TYPE_FILE || bad == TYPE_DIR);
                send_byte(bad);
            end
        endcase
        repeat (12) send_byte(8'($urandom_range(0, 255)));
    endtask

    // result side: random stall per item, check against the oldest expectation
    initial begin
        int        stall;
        t_out_item exp_ev;
        t_out_item got;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = out_calm ? 0 : int'($urandom_range(0, 5));
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            got = out_if.data;
            if (exp_wr == exp_rd) begin
                $error("result item with none expected: kind %0d byte %0h",
                       got.event_kind, got.out_byte);
                mismatches++;
            end else begin
                exp_ev = exp_fifo[exp_rd % EXP_DEPTH];
                exp_rd++;
                check_field("event_kind", 32'(exp_ev.event_kind), 32'(got.event_kind));
                check_field("out_byte", 32'(exp_ev.out_byte), 32'(got.out_byte));
                check_field("field_pos", 32'(exp_ev.field_pos), 32'(got.field_pos));
                check_field("files_left", exp_ev.files_left, got.files_left);
                check_field("proto_version", 32'(exp_ev.proto_version),
                            32'(got.proto_version));
                check_field("error_code", 32'(exp_ev.error_code), 32'(got.error_code));
                check_field("closed", 32'(exp_ev.closed), 32'(got.closed));
                check_field("last", 32'(exp_ev.last), 32'(got.last));
            end
            if ($urandom_range(0, 19) == 0) out_calm = !out_calm;
        end
    end

    // byte side: reset, directed table, random requests, closing tail
    initial begin
        int random_start;
        i_rst_n      = 1'b0;
        in_if.valid <= 1'b0;
        in_if.data  <= '0;
        mdl_phase    = PH_VER;
        mdl_version  = 8'd0;
        mdl_files    = 32'd0;
        mdl_index    = 5'd0;
        mdl_err      = ERR_NONE;

        // largest version, request with zero count
        add_row(typed_row(8'hFF, make_event(K_VERSION, 8'hFF, 5'd0, 32'd0,
                          8'hFF, ERR_NONE, 1'b0, 1'b1)));
        add_row(typed_row(CMD_BACKUP, make_event(K_COMMAND, CMD_BACKUP, 5'd0,
                          32'd0, 8'hFF, ERR_NONE, 1'b0, 1'b1)));
        add_row(row(8'h41));
        add_row(row(8'hFF));
        add_row(typed_row(STR_TERM, make_event(K_NAME_END, STR_TERM, 5'd0,
                          32'd0, 8'hFF, ERR_NONE, 1'b0, 1'b1)));
        repeat (4) add_row(row(8'h00));
        // smallest version, empty name, two directories
        add_row(typed_row(8'h00, make_event(K_VERSION, 8'h00, 5'd0, 32'd0,
                          8'h00, ERR_NONE, 1'b0, 1'b1)));
        add_row(row(CMD_BACKUP));
        add_row(row(STR_TERM));
        add_row(row(8'h00));
        add_row(row(8'h00));
        add_row(row(8'h00));
        add_row(row(8'h02));
        add_row(row(8'h2F));
        add_row(row(STR_TERM));
        add_row(row(TYPE_DIR));
        add_row(row(STR_TERM));
        add_row(row(TYPE_DIR));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < dir_count; i++) begin
            send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].ev);
        end

        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) send_backup_request();

        send_closing_tail();
        in_if.valid <= 1'b0;

        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/brsp_pkg.sv
rtl/brsp_stream_if.sv
rtl/brsp_step.sv
rtl/backup_request_stream_parser.sv
sim/tb_top.sv
